// File: rtl/seam_min_path_finder_defines.svh
// ----------------------------------------------------------------------------
// seam_min_path_finder_defines
// assertion macros used by the seam finder sequencer (smpf_ctrl)
// ----------------------------------------------------------------------------
`ifndef SEAM_MIN_PATH_FINDER_DEFINES_SVH
`define SEAM_MIN_PATH_FINDER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SMPF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SMPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/smpf_pkg.sv
// ----------------------------------------------------------------------------
// smpf_pkg
// shared types and constants of the vertical seam finder
// ----------------------------------------------------------------------------
package smpf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int WEIGHT_W   = 21;
    localparam int COST_W     = 28;
    localparam int STEP_W     = 2;
    localparam int SEAM_W     = 8;
    localparam int CFG_H_W    = 7;
    localparam int CFG_W_W    = 9;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 24;

    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 7'd64;
    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [CFG_W_W-1:0] WIDTH_MIN    = 9'd2;

    // register index, taken from paddr[2]
    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    // step-back codes: which cell of the row below the seam moves to
    localparam logic [STEP_W-1:0] STEP_LEFT  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_MID   = 2'd1;
    localparam logic [STEP_W-1:0] STEP_RIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_ROW_WAIT,
        ST_EMIT,
        ST_STEP
    } smpf_state_t;

    typedef struct packed {
        logic weight_wr;
        logic sweep_issue;
        logic sweep_rd;
        logic bottom;
        logic top;
        logic trace_init;
        logic trace_load;
        logic trace_step;
    } smpf_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } smpf_status_t;

endpackage

// File: rtl/smpf_datapath.sv
// ----------------------------------------------------------------------------
// smpf_datapath
// weight, cost and step-back memories, cost pipeline, seam trace and
// output register
// ----------------------------------------------------------------------------
module smpf_datapath #(
    parameter int MAX_WIDTH  = smpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smpf_pkg::DEF_MAX_HEIGHT,
    parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int CNT_W      = $clog2(MAX_WIDTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  smpf_pkg::smpf_cmd_t            cmd,
    output smpf_pkg::smpf_status_t         stat,
    input  logic [ROW_W-1:0]               row,
    input  logic [CNT_W-1:0]               col,
    input  logic [smpf_pkg::WEIGHT_W-1:0]  weight,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [smpf_pkg::SEAM_W-1:0]    out_column,
    output logic                           out_last
);

    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CELL_DEPTH  = 2 ** ADDR_W;
    localparam int COST_DEPTH  = 2 ** (COL_W + 1);
    localparam int WEIGHT_W    = smpf_pkg::WEIGHT_W;
    localparam int COST_W      = smpf_pkg::COST_W;
    localparam int STEP_W      = smpf_pkg::STEP_W;
    localparam int SEAM_W      = smpf_pkg::SEAM_W;

    logic [WEIGHT_W-1:0] weight_mem [CELL_DEPTH];
    logic [STEP_W-1:0]   step_mem   [CELL_DEPTH];
    logic [COST_W-1:0]   cost_mem   [COST_DEPTH];

    logic [WEIGHT_W-1:0] wgt_rd_reg;
    logic [COST_W-1:0]   cost_rd_reg;
    logic [STEP_W-1:0]   step_rd_reg;

    // stage 1: window over the row below
    logic                s1_valid_reg;
    logic                s1_rd_reg;
    logic [CNT_W-1:0]    s1_idx_reg;
    logic [COST_W-1:0]   win_l_reg;
    logic [COST_W-1:0]   win_m_reg;
    logic [WEIGHT_W-1:0] wprev_reg;

    // stage 2: add and write back
    logic                s2_valid_reg;
    logic [COL_W-1:0]    s2_col_reg;
    logic [COST_W-1:0]   s2_best_reg;
    logic [WEIGHT_W-1:0] s2_wgt_reg;
    logic [STEP_W-1:0]   s2_code_reg;

    // stage 3: running minimum of the top row
    logic                s3_valid_reg;
    logic [COL_W-1:0]    s3_col_reg;
    logic [COST_W-1:0]   s3_sum_reg;
    logic [COST_W-1:0]   min_cost_reg;
    logic [COL_W-1:0]    min_col_reg;

    logic [COL_W-1:0]    trace_col_reg;
    logic [COL_W-1:0]    trace_col_next;

    logic                out_valid_reg;
    logic [SEAM_W-1:0]   out_col_reg;
    logic                out_last_reg;

    logic [COST_W-1:0]   cur;
    logic                has_l;
    logic                has_r;
    logic                lt_ml;
    logic                lt_rl;
    logic                lt_rm;
    logic [COST_W-1:0]   best;
    logic [STEP_W-1:0]   code;
    logic [COST_W-1:0]   sum;
    logic [COL_W+SEAM_W-1:0] trace_ext;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.weight_wr)
        begin
            weight_mem[{row, col[COL_W-1:0]}] <= weight;
        end
        if (cmd.sweep_issue && cmd.sweep_rd)
        begin
            wgt_rd_reg  <= weight_mem[{row, col[COL_W-1:0]}];
            cost_rd_reg <= cost_mem[{~row[0], col[COL_W-1:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            cost_mem[{row[0], s2_col_reg}] <= sum;
            step_mem[{row, s2_col_reg}]    <= s2_code_reg;
        end
        if (cmd.trace_load)
        begin
            step_rd_reg <= step_mem[{row, trace_col_reg}];
        end
    end

    // cheapest of up to three cells below, ties to the lowest column
    always_comb
    begin
        cur   = (s1_rd_reg && !cmd.bottom) ? cost_rd_reg : '0;
        has_l = s1_idx_reg > CNT_W'(1);
        has_r = s1_rd_reg;
        lt_ml = win_m_reg < win_l_reg;
        lt_rl = cur < win_l_reg;
        lt_rm = cur < win_m_reg;
        best  = win_m_reg;
        code  = smpf_pkg::STEP_MID;
        if (has_l && !lt_ml)
        begin
            if (has_r && lt_rl)
            begin
                best = cur;
                code = smpf_pkg::STEP_RIGHT;
            end
            else
            begin
                best = win_l_reg;
                code = smpf_pkg::STEP_LEFT;
            end
        end
        else if (has_r && lt_rm)
        begin
            best = cur;
            code = smpf_pkg::STEP_RIGHT;
        end
    end

    assign sum = COST_W'(s2_wgt_reg) + s2_best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.sweep_issue;
            s2_valid_reg <= s1_valid_reg && (s1_idx_reg != '0);
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rd_reg  <= cmd.sweep_rd;
        s1_idx_reg <= col;
        if (s1_valid_reg)
        begin
            win_l_reg <= win_m_reg;
            win_m_reg <= cur;
            wprev_reg <= wgt_rd_reg;
        end
        s2_col_reg  <= COL_W'(s1_idx_reg - CNT_W'(1));
        s2_best_reg <= best;
        s2_wgt_reg  <= wprev_reg;
        s2_code_reg <= code;
        s3_col_reg  <= s2_col_reg;
        s3_sum_reg  <= sum;
        if (s3_valid_reg && cmd.top && ((s3_col_reg == '0) || (s3_sum_reg < min_cost_reg)))
        begin
            min_cost_reg <= s3_sum_reg;
            min_col_reg  <= s3_col_reg;
        end
    end

    // follow the stored choices down the map
    always_comb
    begin
        trace_col_next = trace_col_reg;
        if (cmd.trace_init)
        begin
            trace_col_next = min_col_reg;
        end
        else if (cmd.trace_step)
        begin
            case (step_rd_reg)
                smpf_pkg::STEP_LEFT:  trace_col_next = trace_col_reg - COL_W'(1);
                smpf_pkg::STEP_RIGHT: trace_col_next = trace_col_reg + COL_W'(1);
                default:              trace_col_next = trace_col_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        trace_col_reg <= trace_col_next;
    end

    assign trace_ext = {{SEAM_W{1'b0}}, trace_col_reg};

    // output register, refilled while the previous result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.trace_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.trace_load)
        begin
            out_col_reg  <= trace_ext[SEAM_W-1:0];
            out_last_reg <= cmd.bottom;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_column    = out_col_reg;
    assign out_last      = out_last_reg;
    assign stat.busy     = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

// File: rtl/smpf_ctrl.sv
// ----------------------------------------------------------------------------
// smpf_ctrl
// sequencer for loading, the bottom-up cost sweep and the seam trace
// ----------------------------------------------------------------------------
`include "seam_min_path_finder_defines.svh"

module smpf_ctrl #(
    parameter int MAX_WIDTH  = smpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smpf_pkg::DEF_MAX_HEIGHT,
    parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    parameter int CNT_W      = $clog2(MAX_WIDTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          cfg_clear,
    input  logic [smpf_pkg::CFG_H_W-1:0]  cfg_height,
    input  logic [smpf_pkg::CFG_W_W-1:0]  cfg_width,
    input  smpf_pkg::smpf_status_t        stat,
    output smpf_pkg::smpf_cmd_t           cmd,
    output logic [ROW_W-1:0]              row,
    output logic [CNT_W-1:0]              col
);

    smpf_pkg::smpf_state_t state_reg;
    smpf_pkg::smpf_state_t state_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] eff_w;
    logic [CNT_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    // clamp the size registers into the supported range
    always_comb
    begin
        if (cfg_width < smpf_pkg::WIDTH_MIN)
        begin
            eff_w = CNT_W'(2);
        end
        else if (32'(cfg_width) > 32'(MAX_WIDTH))
        begin
            eff_w = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CNT_W'(cfg_width);
        end

        if (cfg_height == '0)
        begin
            h_last = '0;
        end
        else if (32'(cfg_height) > 32'(MAX_HEIGHT))
        begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = ROW_W'(cfg_height - smpf_pkg::CFG_H_W'(1));
        end
    end

    assign w_last = eff_w - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            smpf_pkg::ST_LOAD:
            begin
                if (cfg_clear)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else if (s_tvalid)
                begin
                    if (col_reg == w_last)
                    begin
                        col_next = '0;
                        if (row_reg == h_last)
                        begin
                            state_next = smpf_pkg::ST_ROW;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + CNT_W'(1);
                    end
                end
            end
            smpf_pkg::ST_ROW:
            begin
                // one extra slot past the last column flushes the window
                if (col_reg == eff_w)
                begin
                    col_next   = '0;
                    state_next = smpf_pkg::ST_ROW_WAIT;
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end
            smpf_pkg::ST_ROW_WAIT:
            begin
                if (!stat.busy)
                begin
                    if (row_reg == '0)
                    begin
                        state_next = smpf_pkg::ST_EMIT;
                    end
                    else
                    begin
                        row_next   = row_reg - ROW_W'(1);
                        state_next = smpf_pkg::ST_ROW;
                    end
                end
            end
            smpf_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (row_reg == h_last)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        state_next = smpf_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = smpf_pkg::ST_STEP;
                    end
                end
            end
            smpf_pkg::ST_STEP:
            begin
                row_next   = row_reg + ROW_W'(1);
                state_next = smpf_pkg::ST_EMIT;
            end
            default:
            begin
                state_next = smpf_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.bottom = row_reg == h_last;
        cmd.top    = row_reg == '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            smpf_pkg::ST_LOAD:
            begin
                s_tready      = 1'b1;
                cmd.weight_wr = s_tvalid;
            end
            smpf_pkg::ST_ROW:
            begin
                cmd.sweep_issue = 1'b1;
                cmd.sweep_rd    = col_reg != eff_w;
            end
            smpf_pkg::ST_ROW_WAIT:
            begin
                cmd.trace_init = !stat.busy && (row_reg == '0);
            end
            smpf_pkg::ST_EMIT:
            begin
                cmd.trace_load = stat.out_free;
            end
            smpf_pkg::ST_STEP:
            begin
                cmd.trace_step = 1'b1;
            end
            default:
            begin
                cmd = cmd;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smpf_pkg::ST_LOAD;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    assign row = row_reg;
    assign col = col_reg;

    `SMPF_ASSERT_IMPLY(a_load_idle, s_tvalid && s_tready, !stat.busy, "weight taken while sweep busy")
    `SMPF_ASSERT_IMPLY(a_trace_free, cmd.trace_load, stat.out_free, "seam result overwrote pending output")
    `SMPF_ASSERT_IMPLY(a_sweep_col, state_reg == smpf_pkg::ST_ROW, col_reg <= eff_w, "sweep ran past row end")
    `SMPF_ASSERT_ALWAYS(a_row_range, row_reg <= h_last, "row counter beyond map height")

endmodule

// File: rtl/seam_min_path_finder.sv
// ----------------------------------------------------------------------------
// seam_min_path_finder
// minimum-cost vertical seam of an energy map, one seam column per row out
// ----------------------------------------------------------------------------
// loading: one weight per cycle while the block is in its load state, h*w weights for a map
// cost sweep: starts after the last weight, one cell per cycle
//   through the cost row memory, plus a three-stage drain at each row end
// trace: per row, a step-back memory read, then a column update
// reset clears the control state and the size registers only; the memories need no clearing
module seam_min_path_finder #(
    parameter int MAX_WIDTH  = smpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smpf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // weight
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smpf_pkg::S_TDATA_W-1:0]   s_tdata,     // [20:0] weight
    // seam_column
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smpf_pkg::SEAM_W-1:0]      m_tdata,     // [7:0] seam_column
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smpf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [smpf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [smpf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    logic [smpf_pkg::CFG_H_W-1:0] height_reg;
    logic [smpf_pkg::CFG_W_W-1:0] width_reg;
    logic                         cfg_wr;
    smpf_pkg::smpf_cmd_t          cmd;
    smpf_pkg::smpf_status_t       stat;
    logic [ROW_W-1:0]             row;
    logic [CNT_W-1:0]             col;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= smpf_pkg::HEIGHT_RESET;
            width_reg  <= smpf_pkg::WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                smpf_pkg::REG_HEIGHT: height_reg <= pwdata[smpf_pkg::CFG_H_W-1:0];
                smpf_pkg::REG_WIDTH:  width_reg  <= pwdata[smpf_pkg::CFG_W_W-1:0];
                default:              height_reg <= height_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            smpf_pkg::REG_HEIGHT: prdata = smpf_pkg::APB_DATA_W'(height_reg);
            smpf_pkg::REG_WIDTH:  prdata = smpf_pkg::APB_DATA_W'(width_reg);
            default:              prdata = '0;
        endcase
    end

    smpf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_W      (ROW_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .cfg_clear  (cfg_wr),
        .cfg_height (height_reg),
        .cfg_width  (width_reg),
        .stat       (stat),
        .cmd        (cmd),
        .row        (row),
        .col        (col)
    );

    smpf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_W      (ROW_W),
        .COL_W      (COL_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .row        (row),
        .col        (col),
        .weight     (s_tdata[smpf_pkg::WEIGHT_W-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_column (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

// File: tb/seam_min_path_finder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seam_min_path_finder_checker
// watches the register port and both streams, solves each completed energy
// map on its own and compares every seam row the block sends against it
// ----------------------------------------------------------------------------
module seam_min_path_finder_checker
    import smpf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,     // [20:0] weight
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [SEAM_W-1:0]       m_tdata,     // [7:0] seam_column
    input  logic                    m_tlast,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic                    pready,
    output int                      mismatches,
    output int                      pending_rows
);

    typedef struct packed {
        logic [SEAM_W-1:0] column;
        logic              last;
    } seam_row_t;

    logic [CFG_H_W-1:0]  height_reg;
    logic [CFG_W_W-1:0]  width_reg;
    int unsigned         loaded;
    int                  errors;

    logic [WEIGHT_W-1:0] energy     [MAX_HEIGHT][MAX_WIDTH];
    logic [STEP_W-1:0]   step_dir   [MAX_HEIGHT][MAX_WIDTH];
    logic [COST_W-1:0]   cost_below [MAX_WIDTH];
    logic [COST_W-1:0]   cost_here  [MAX_WIDTH];

    seam_row_t           seam_q [$];

    function automatic int rows_used();
        if (height_reg == '0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic int cols_used();
        if (width_reg < WIDTH_MIN)
            return int'(WIDTH_MIN);
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    // bottom-up cost sweep, then trace the seam from the cheapest top cell
    task automatic solve_map(input int rows, input int cols);
        int        r;
        int        c;
        int        k;
        int        lo;
        int        hi;
        int        best;
        int        col;
        seam_row_t entry;
        for (c = 0; c < cols; c++)
            cost_below[c] = energy[rows-1][c];
        for (r = rows - 2; r >= 0; r--)
        begin
            for (c = 0; c < cols; c++)
            begin
                lo   = (c == 0) ? 0 : c - 1;
                hi   = (c + 1 < cols) ? c + 1 : c;
                best = lo;
                for (k = lo + 1; k <= hi; k++)
                    if (cost_below[k] < cost_below[best])
                        best = k;
                cost_here[c]   = energy[r][c] + cost_below[best];
                step_dir[r][c] = STEP_W'(best + 1 - c);
            end
            for (c = 0; c < cols; c++)
                cost_below[c] = cost_here[c];
        end
        col = 0;
        for (c = 1; c < cols; c++)
            if (cost_below[c] < cost_below[col])
                col = c;
        for (r = 0; r < rows; r++)
        begin
            if (r > 0)
            begin
                case (step_dir[r-1][col])
                    STEP_LEFT:  col = col - 1;
                    STEP_RIGHT: col = col + 1;
                    default:    col = col;
                endcase
            end
            entry.column = SEAM_W'(col);
            entry.last   = (r == rows - 1);
            seam_q.push_back(entry);
        end
    endtask

    task automatic take_weight(input logic [WEIGHT_W-1:0] w);
        int rows;
        int cols;
        int unsigned cells;
        rows  = rows_used();
        cols  = cols_used();
        cells = rows * cols;
        if (loaded >= cells)
            loaded = 0;
        energy[loaded / cols][loaded % cols] = w;
        loaded++;
        if (loaded == cells)
        begin
            loaded = 0;
            solve_map(rows, cols);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        seam_row_t want;
        if (!rst_n)
        begin
            height_reg = HEIGHT_RESET;
            width_reg  = WIDTH_RESET;
            loaded     = 0;
            errors     = 0;
            seam_q.delete();
            mismatches   <= 0;
            pending_rows <= 0;
        end
        else
        begin
            // results first: anything leaving now was computed earlier
            if (m_tvalid && m_tready)
            begin
                if (seam_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected seam row, expected none, got column %0d last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = seam_q.pop_front();
                    if (m_tdata !== want.column)
                    begin
                        errors++;
                        $display("%0t: seam column mismatch, expected %0d, got %0d",
                                 $time, want.column, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: last row flag mismatch, expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                // any listed register write drops a partial map
                if (paddr[2] == REG_HEIGHT)
                    height_reg = pwdata[CFG_H_W-1:0];
                else
                    width_reg = pwdata[CFG_W_W-1:0];
                loaded = 0;
            end
            if (s_tvalid && s_tready)
                take_weight(s_tdata[WEIGHT_W-1:0]);
            mismatches   <= errors;
            pending_rows <= seam_q.size();
        end
    end

endmodule

// File: tb/seam_min_path_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seam_min_path_finder_tb
// feeds energy maps of many sizes through the seam finder under random
// input gaps and output stalls, with size changes between maps
// ----------------------------------------------------------------------------
module seam_min_path_finder_tb;

    import smpf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int PLAN_LEN     = 6;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_MAX  = '1;
    localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};

    typedef struct {
        int raw_h;
        int raw_w;
        int rows;
        int cols;
        int maps;
        bit hold;
    } phase_t;

    typedef enum {RX_FREE, RX_HALF, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    typedef enum {FILL_ANY, FILL_TIES, FILL_EXTREME, FILL_MIXED} fill_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // [20:0] weight
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SEAM_W-1:0]     m_tdata;     // [7:0] seam_column
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending_rows;
    int                    cycle_count = 0;
    bit                    stall_long;
    int                    burst_left;
    int                    cur_rows;
    int                    cur_cols;
    logic [WEIGHT_W-1:0]   pixels [$];

    seam_min_path_finder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    seam_min_path_finder_checker checker_i (.*);

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: stall pattern drawn at random from the receiver modes, with long holds on request
    initial
    begin : receiver
        rx_mode_t mode;
        int       span;
        m_tready = 1'b0;
        mode     = RX_FREE;
        span     = 0;
        forever
        begin
            @(posedge clk);
            if (stall_long)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                stall_long = 1'b0;
            end
            if (span == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 4));
                span = $urandom_range(10, 80);
            end
            span--;
            case (mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 4) != 0);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ((cycle_count % 3) != 0);
            endcase
        end
    end

    function automatic int settle_cycles();
        return cur_rows * (cur_cols + 5) + 10;
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // both registers in random order, junk above the register fields
    task automatic configure(input phase_t p);
        logic [APB_DATA_W-1:0] hdata;
        logic [APB_DATA_W-1:0] wdata;
        hdata = (APB_DATA_W'($urandom) << CFG_H_W) | APB_DATA_W'(p.raw_h);
        wdata = (APB_DATA_W'($urandom) << CFG_W_W) | APB_DATA_W'(p.raw_w);
        if ($urandom_range(0, 1) == 1)
        begin
            apb_write(ADDR_HEIGHT, hdata);
            apb_write(ADDR_WIDTH, wdata);
        end
        else
        begin
            apb_write(ADDR_WIDTH, wdata);
            apb_write(ADDR_HEIGHT, hdata);
        end
        cur_rows = p.rows;
        cur_cols = p.cols;
    endtask

    // empties the weight queue in bursts; every caller then calls wait_idle
    task automatic send_pixels();
        int gap;
        while (pixels.size() != 0)
        begin
            s_tdata  <= {{(S_TDATA_W - WEIGHT_W){1'b0}}, pixels.pop_front()};
            s_tvalid <= 1'b1;
            do @(posedge clk); while (!s_tready);
            if (burst_left > 0)
                burst_left--;
            else
            begin
                s_tvalid <= 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                         : $urandom_range(0, 12);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        @(posedge clk);
        while (pending_rows != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic queue_random_map(input int cells);
        fill_t               style;
        int                  i;
        logic [WEIGHT_W-1:0] w;
        style = fill_t'($urandom_range(0, 3));
        for (i = 0; i < cells; i++)
        begin
            case (style)
                FILL_ANY:     w = WEIGHT_W'($urandom);
                FILL_TIES:    w = WEIGHT_W'($urandom_range(0, 3));
                FILL_EXTREME: w = ($urandom_range(0, 1) == 1) ? WEIGHT_MAX : '0;
                default:      w = ($urandom_range(0, 2) == 0) ? WEIGHT_W'($urandom)
                                                              : WEIGHT_W'($urandom_range(0, 15));
            endcase
            pixels.push_back(w);
        end
    endtask

    initial
    begin : stimulus
        phase_t plan [PLAN_LEN];
        phase_t p;
        int     i;
        int     m;
        int     k;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        stall_long = 1'b0;
        burst_left = 0;
        cur_rows   = DEF_MAX_HEIGHT;
        cur_cols   = DEF_MAX_WIDTH;

        plan[0] = '{3, 4, 3, 4, 1, 1'b0};
        plan[1] = '{4, 4, 4, 4, 2, 1'b1};
        plan[2] = '{2, 2, 2, 2, 2, 1'b0};
        plan[3] = '{127, 2, 64, 2, 1, 1'b0};
        plan[4] = '{5, 3, 5, 3, 1, 1'b0};
        plan[5] = '{4, 7, 4, 7, 1, 1'b0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single row: cheapest cell, extremes and a tie
        p = '{1, 2, 1, 2, 0, 1'b0};
        configure(p);
        pixels.push_back(WEIGHT_MAX);
        pixels.push_back('0);
        pixels.push_back('0);
        pixels.push_back('0);
        send_pixels();
        wait_idle(settle_cycles());

        // height zero and width below two both clamp
        p = '{0, 1, 1, 2, 0, 1'b0};
        configure(p);
        pixels.push_back(21'd5);
        pixels.push_back(21'd3);
        send_pixels();
        wait_idle(settle_cycles());

        // all-equal map: every choice falls to the lowest column
        p = '{3, 3, 3, 3, 0, 1'b0};
        configure(p);
        for (k = 0; k < 9; k++)
            pixels.push_back('0);
        // partial map, dropped by the width write below
        for (k = 0; k < 4; k++)
            pixels.push_back(WEIGHT_W'($urandom));
        send_pixels();
        wait_idle(settle_cycles());
        apb_write(ADDR_WIDTH, (APB_DATA_W'($urandom) << CFG_W_W) | APB_DATA_W'(3));
        pixels.push_back(WEIGHT_MAX);
        pixels.push_back(21'd3);
        pixels.push_back(WEIGHT_MAX);
        pixels.push_back(21'd1);
        pixels.push_back(WEIGHT_MAX);
        pixels.push_back('0);
        pixels.push_back('0);
        pixels.push_back(WEIGHT_MAX);
        pixels.push_back(21'd2);
        send_pixels();
        wait_idle(settle_cycles());

        for (i = 0; i < PLAN_LEN; i++)
        begin
            p = plan[i];
            // sometimes leave a short broken map behind before the size change
            if ($urandom_range(0, 1) == 1)
            begin
                for (k = (cur_rows * cur_cols > 7) ? $urandom_range(1, 6)
                                                   : $urandom_range(1, cur_rows * cur_cols - 1);
                     k > 0; k--)
                    pixels.push_back(WEIGHT_W'($urandom));
                send_pixels();
                wait_idle(settle_cycles());
            end
            configure(p);
            for (m = 0; m < p.maps; m++)
                queue_random_map(p.rows * p.cols);
            if (p.hold)
                stall_long = 1'b1;
            send_pixels();
            wait_idle(settle_cycles());
        end

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0 && pending_rows == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
